### rtl/core/sbs_pkg.sv
package sbs_pkg;

   // key and result widths are fixed by the item format
   localparam int KEY_W            = 32;
   localparam int MODE_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int POS_W            = 10;
   localparam int TABLE_DEPTH_DEF  = 1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_FINISH
   } state_type;

endpackage

### rtl/core/sbs_key_ram.sv
// key storage: one write port, one registered read port
module sbs_key_ram #(
   parameter int DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [IW-1:0]                   wr_addr,
   input  logic signed [sbs_pkg::KEY_W-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [IW-1:0]                   rd_addr,
   output logic signed [sbs_pkg::KEY_W-1:0] rd_data
);

   logic [sbs_pkg::KEY_W-1:0] mem [DEPTH];
   logic [sbs_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

### rtl/core/sorted_table_binary_search_unit.sv
// Sorted key table with a binary search sequencer.
// Input channel (req_valid/req_ready): req_mode selects clear, append or search;
// req_key is the key to append or the target of the search. Every item gives
// exactly one result on the rsp_ channel: rsp_status (ok/found, not present,
// table full) and rsp_position (index of the match, else zero).
// Only one item is in work at a time; req_ready is high only while idle.
// Clear, append and the unused mode go from accept to S_FINISH, which then
// loads the output register. Each search probe is one registered key RAM read
// (S_PROBE), then one signed compare that narrows the range (S_CMP); a search
// ends on a hit or when the range runs empty, after p probes with
// p <= floor(log2(entries)) + 1, i.e. at most 11 probes for 1024 entries.
// The result sits in an output register: a stalled receiver holds it there,
// the block may already accept and work the next item, and only the final
// hand-off to the output register waits for rsp_ready.
// Reset (synchronous, active high) empties the table and drops any pending
// result; stored keys are not cleared, they are simply out of range.
module sorted_table_binary_search_unit #(
   parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sbs_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [sbs_pkg::KEY_W-1:0]   req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sbs_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sbs_pkg::POS_W-1:0]          rsp_position
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;  // entry index
   localparam int CW = $clog2(TABLE_DEPTH + 1);                      // count 0..DEPTH

   sbs_pkg::state_type state_ff, state_in;

   // search range kept as [lo, hi) so it never goes negative
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic signed [sbs_pkg::KEY_W-1:0] target_ff, target_in;

   // finished result waiting for the output register
   sbs_pkg::status_type res_status_ff, res_status_in;
   logic [sbs_pkg::POS_W-1:0] res_pos_ff, res_pos_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [sbs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sbs_pkg::POS_W-1:0] rsp_position_ff, rsp_position_in;

   logic accept;
   logic range_empty;
   logic out_free;
   logic [CW:0] mid_sum;
   logic [IW-1:0] mid_calc;
   logic [CW-1:0] mid_next;
   logic table_full;

   logic ram_wr_en;
   logic ram_rd_en;
   logic signed [sbs_pkg::KEY_W-1:0] ram_rd_data;

   sbs_key_ram #(
      .DEPTH (TABLE_DEPTH),
      .IW    (IW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (req_key),
      .rd_en   (ram_rd_en),
      .rd_addr (mid_calc),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == sbs_pkg::S_IDLE);
   assign accept      = req_valid && req_ready;
   assign range_empty = (lo_ff >= hi_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign table_full  = (count_ff == CW'(TABLE_DEPTH));

   // midpoint of [lo, hi-1], rounded down; only used when the range is not empty
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign mid_calc = IW'(mid_sum >> 1);
   assign mid_next = CW'(mid_ff) + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbs_pkg::S_IDLE: begin
            if (accept) begin
               if (sbs_pkg::mode_type'(req_mode) == sbs_pkg::MODE_SEARCH) begin
                  state_in = sbs_pkg::S_PROBE;
               end else begin
                  state_in = sbs_pkg::S_FINISH;
               end
            end
         end
         sbs_pkg::S_PROBE: begin
            state_in = range_empty ? sbs_pkg::S_FINISH : sbs_pkg::S_CMP;
         end
         sbs_pkg::S_CMP: begin
            state_in = (ram_rd_data == target_ff) ? sbs_pkg::S_FINISH : sbs_pkg::S_PROBE;
         end
         sbs_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = sbs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbs_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      target_in       = target_ff;
      res_status_in   = res_status_ff;
      res_pos_in      = res_pos_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      case (state_ff)
         sbs_pkg::S_IDLE: begin
            if (accept) begin
               res_status_in = sbs_pkg::STATUS_OK;
               res_pos_in    = '0;
               case (sbs_pkg::mode_type'(req_mode))
                  sbs_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  sbs_pkg::MODE_APPEND: begin
                     if (table_full) begin
                        res_status_in = sbs_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  sbs_pkg::MODE_SEARCH: begin
                     target_in = req_key;
                     lo_in     = '0;
                     hi_in     = count_ff;
                  end
                  default: begin
                     // unused mode: no state change, plain ok
                  end
               endcase
            end
         end
         sbs_pkg::S_PROBE: begin
            if (range_empty) begin
               res_status_in = sbs_pkg::STATUS_ABSENT;
               res_pos_in    = '0;
            end else begin
               ram_rd_en = 1'b1;
               mid_in    = mid_calc;
            end
         end
         sbs_pkg::S_CMP: begin
            if (ram_rd_data == target_ff) begin
               res_status_in = sbs_pkg::STATUS_OK;
               res_pos_in    = sbs_pkg::POS_W'(mid_ff);
            end else if (ram_rd_data < target_ff) begin
               lo_in = mid_next;
            end else begin
               hi_in = CW'(mid_ff);
            end
         end
         sbs_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_position_in = res_pos_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbs_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      target_ff       <= target_in;
      res_status_ff   <= res_status_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

endmodule

### verif/sbs_answer_checker.sv
module sbs_answer_checker #(
   parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [sbs_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [sbs_pkg::KEY_W-1:0]    req_key,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [sbs_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [sbs_pkg::POS_W-1:0]           rsp_position,
   output int                                  error_count,
   output int                                  pending_count
);

   typedef struct packed {
      sbs_pkg::status_type            status;
      logic [sbs_pkg::POS_W-1:0]      position;
   } answer_type;

   logic signed [sbs_pkg::KEY_W-1:0] key_store [TABLE_DEPTH];
   int                               fill_count = 0;
   answer_type                       answer_queue[$];
   int                               fail_total = 0;

   assign error_count   = fail_total;
   assign pending_count = answer_queue.size();

   // applies one item to the shadow table and returns the answer it should give
   function automatic answer_type table_answer(input logic [sbs_pkg::MODE_W-1:0] mode_bits,
                                               input logic signed [sbs_pkg::KEY_W-1:0] key);
      answer_type ans;
      int         lo;
      int         hi;
      int         mid;
      bit         hit;
      ans.status   = sbs_pkg::STATUS_OK;
      ans.position = '0;
      case (sbs_pkg::mode_type'(mode_bits))
         sbs_pkg::MODE_CLEAR: begin
            fill_count = 0;
         end
         sbs_pkg::MODE_APPEND: begin
            if (fill_count >= TABLE_DEPTH) begin
               ans.status = sbs_pkg::STATUS_FULL;
            end else begin
               key_store[fill_count] = key;
               fill_count++;
            end
         end
         sbs_pkg::MODE_SEARCH: begin
            ans.status = sbs_pkg::STATUS_ABSENT;
            lo  = 0;
            hi  = fill_count - 1;
            hit = 1'b0;
            while (lo <= hi && !hit) begin
               mid = (lo + hi) / 2;
               if (key_store[mid] == key) begin
                  hit          = 1'b1;
                  ans.status   = sbs_pkg::STATUS_OK;
                  ans.position = sbs_pkg::POS_W'(mid);
               end else if (key_store[mid] < key) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         fill_count = 0;
         answer_queue.delete();
      end else begin
         if (req_valid && req_ready)
            answer_queue.push_back(table_answer(req_mode, req_key));
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d position %0d",
                        $time, rsp_status, rsp_position);
               fail_total++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_total++;
               end
               if (rsp_position !== want.position) begin
                  $display("%0t: position mismatch: expected %0d actual %0d",
                           $time, want.position, rsp_position);
                  fail_total++;
               end
            end
         end
      end
   end

endmodule

### verif/testbench.sv
module testbench;

   localparam int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF;
   localparam int KEY_MIN     = int'(32'h8000_0000);
   localparam int KEY_MAX     = 32'h7FFF_FFFF;

   logic                             clock;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [sbs_pkg::MODE_W-1:0]       req_mode  = sbs_pkg::MODE_CLEAR;
   logic signed [sbs_pkg::KEY_W-1:0] req_key   = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [sbs_pkg::STATUS_W-1:0]     rsp_status;
   logic [sbs_pkg::POS_W-1:0]        rsp_position;

   int error_count;
   int pending_count;

   // idle odds in percent, changed per phase
   int send_idle_pct = 8;
   int recv_idle_pct = 79;

   // stimulus-side copy of the appended keys, used only to aim searches at stored keys and their neighbors
   int filled_keys[$];
   int item_count = 0;

   sorted_table_binary_search_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position)
   );

   sbs_answer_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver stalls at random, one coin per cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one item and hold it until accepted. Called at a rising edge.
   // Valid is only dropped when a gap is taken, so a back-to-back item never
   // sees valid lowered and raised in the same step.
   task automatic send_item(input sbs_pkg::mode_type mode, input int key);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      // req_ready read right after the edge is still its pre-edge value
      do @(posedge clock); while (!req_ready);
      item_count++;
   endtask

   task automatic append_key(input int key);
      send_item(sbs_pkg::MODE_APPEND, key);
      if (filled_keys.size() < TABLE_DEPTH)
         filled_keys.push_back(key);
   endtask

   task automatic clear_table();
      send_item(sbs_pkg::MODE_CLEAR, int'($urandom()));
      filled_keys.delete();
   endtask

   // searches aimed at stored keys, their neighbors, the extremes and noise
   task automatic search_batch(input int count);
      for (int i = 0; i < count; i++) begin
         int sel;
         int key;
         sel = $urandom_range(9);
         if (filled_keys.size() != 0 && sel < 5) begin
            key = filled_keys[$urandom_range(filled_keys.size() - 1)];
         end else if (filled_keys.size() != 0 && sel < 7) begin
            key = filled_keys[$urandom_range(filled_keys.size() - 1)];
            key = $urandom_range(1) ? key + 1 : key - 1;
         end else if (sel == 7) begin
            key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
         end else begin
            key = int'($urandom());
         end
         send_item(sbs_pkg::MODE_SEARCH, key);
      end
   endtask

   // Mostly: clear, append an ascending run, then search it.
   // Now and then the clear is skipped, an out-of-order key or an unused
   // mode is slipped in, so broken tables get searched too.
   task automatic run_sequence();
      int count;
      bit narrow;
      int fresh[$];
      if ($urandom_range(7) != 0)
         clear_table();
      count  = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
      narrow = ($urandom_range(3) == 0);
      repeat (count)
         fresh.push_back(narrow ? int'($urandom_range(63)) - 32 : int'($urandom()));
      fresh.sort();
      foreach (fresh[i]) begin
         if ($urandom_range(29) == 0)
            append_key(int'($urandom()));
         if ($urandom_range(49) == 0)
            send_item(sbs_pkg::MODE_NONE, int'($urandom()));
         append_key(fresh[i]);
      end
      search_batch($urandom_range(3, 14));
   endtask

   // fill every slot with spread ascending keys, then bump into the full table
   task automatic fill_whole_table();
      clear_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         longint wide_key;
         wide_key = -64'sd2147483648 + longint'(i) * 64'sd4194304
                    + longint'($urandom_range(4194303));
         append_key(int'(wide_key));
      end
      append_key(KEY_MAX);
      append_key(int'($urandom()));
      send_item(sbs_pkg::MODE_SEARCH, filled_keys[0]);
      send_item(sbs_pkg::MODE_SEARCH, filled_keys[TABLE_DEPTH - 1]);
      send_item(sbs_pkg::MODE_SEARCH, filled_keys[TABLE_DEPTH / 2]);
      search_batch(40);
   endtask

   initial begin
      int phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      send_item(sbs_pkg::MODE_SEARCH, 0);       // empty table right after reset
      send_item(sbs_pkg::MODE_NONE, int'(32'hFFFF_FFFF)); // unused mode is ignored
      clear_table();
      send_item(sbs_pkg::MODE_SEARCH, KEY_MIN); // empty table after a clear
      append_key(KEY_MIN);
      append_key(-1);
      append_key(0);
      append_key(1);
      append_key(KEY_MAX);
      send_item(sbs_pkg::MODE_SEARCH, KEY_MIN); // hit at position zero
      send_item(sbs_pkg::MODE_SEARCH, -1);
      send_item(sbs_pkg::MODE_SEARCH, 0);
      send_item(sbs_pkg::MODE_SEARCH, 1);
      send_item(sbs_pkg::MODE_SEARCH, KEY_MAX); // hit at the last entry
      send_item(sbs_pkg::MODE_SEARCH, 2);       // miss between entries
      send_item(sbs_pkg::MODE_SEARCH, KEY_MIN + 1);
      send_item(sbs_pkg::MODE_NONE, 0);
      send_item(sbs_pkg::MODE_SEARCH, 1);       // table untouched by unused mode
      append_key(5);                            // out of order after the max
      send_item(sbs_pkg::MODE_SEARCH, 5);
      send_item(sbs_pkg::MODE_SEARCH, KEY_MAX);
      clear_table();
      send_item(sbs_pkg::MODE_SEARCH, 0);       // old keys out of range now
      append_key(7);
      send_item(sbs_pkg::MODE_SEARCH, 7);

      // ---- random part: slow sender is rare, receiver stalls a lot ----
      phase_end = item_count + 50;
      while (item_count < phase_end)
         run_sequence();

      // ---- sender idles a lot, receiver rarely ----
      send_idle_pct = 79;
      recv_idle_pct = 8;
      phase_end = item_count + 50;
      while (item_count < phase_end)
         run_sequence();

      // ---- full speed: fill the whole table, then a few short runs ----
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_whole_table();
      phase_end = item_count + 20;
      while (item_count < phase_end)
         run_sequence();

      req_valid <= 1'b0;

      // drain, then give the block a search's worth of cycles to misbehave
      for (int w = 0; w < 100000 && pending_count != 0; w++)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
